// ----- rtl/ssc_pkg.sv -----
// Shared types for the segment closest-point pipeline.
package ssc_pkg;

  // Pipeline control handed to each stage group: advance enable and entry valid.
  typedef struct packed {
    logic en;
    logic vld;
  } pipe_ctl_t;

endpackage

// ----- rtl/ssc_delay.sv -----
// Payload delay line that advances with the pipeline enable.
module ssc_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap_r [DEPTH];

  // Shift one place per advancing cycle
  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d;
      for (int k = 1; k < DEPTH; k++) begin
        tap_r[k] <= tap_r[k-1];
      end
    end
  end

  assign q = tap_r[DEPTH-1];

endmodule

// ----- rtl/ssc_mul.sv -----
// Two-stage signed multiplier built from four half-width partial products.
module ssc_mul #(
  parameter int W = 68
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  localparam int H  = W / 2;
  localparam int HW = W - H;

  logic signed [HW-1:0]   ah, bh;
  logic        [H-1:0]    al, bl;
  logic signed [2*HW-1:0] hh_r;
  logic signed [HW+H:0]   hl_r, lh_r;
  logic        [2*H-1:0]  ll_r;
  logic signed [2*W-1:0]  p_r;

  assign ah = $signed(a[W-1:H]);
  assign bh = $signed(b[W-1:H]);
  assign al = a[H-1:0];
  assign bl = b[H-1:0];

  // Form partial products
  always_ff @(posedge clk) begin
    if (en) begin
      hh_r <= ah * bh;
      hl_r <= ah * $signed({1'b0, bl});
      lh_r <= $signed({1'b0, al}) * bh;
      ll_r <= al * bl;
    end
  end

  // Align and sum partial products
  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= ((2*W)'(hh_r) <<< (2*H)) + ((2*W)'(hl_r) <<< H)
           + ((2*W)'(lh_r) <<< H) + (2*W)'($signed({1'b0, ll_r}));
    end
  end

  assign p = p_r;

endmodule

// ----- rtl/ssc_div.sv -----
// Pipelined clamped fraction num/den, one quotient bit per stage.
module ssc_div #(
  parameter int NW = 138,
  parameter int QB = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ssc_pkg::pipe_ctl_t   ctl,
  input  logic signed [NW-1:0] num,
  input  logic signed [NW-1:0] den,
  output logic                 out_vld,
  output logic [QB:0]          quo
);

  logic [NW-1:0] r_r   [QB+1];
  logic [NW-1:0] d_r   [QB+1];
  logic [QB-1:0] q_r   [QB+1];
  logic          run_r [QB+1];
  logic          one_r [QB+1];
  logic          v_r   [QB+1];

  // Classify: nonpositive numerator, saturated, or divide
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (ctl.en) begin
      v_r[0] <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      one_r[0] <= (num > 0) && (num >= den);
      run_r[0] <= (num > 0) && (num < den) && (den > 0);
      r_r[0]   <= num;
      d_r[0]   <= den;
      q_r[0]   <= '0;
    end
  end

  // Restoring division steps
  for (genvar k = 1; k <= QB; k++) begin : g_step
    logic [NW-1:0] r2;
    logic          ge;

    assign r2 = r_r[k-1] << 1;
    assign ge = r2 >= d_r[k-1];

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ctl.en) begin
        v_r[k] <= v_r[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        r_r[k]   <= ge ? r2 - d_r[k-1] : r2;
        d_r[k]   <= d_r[k-1];
        q_r[k]   <= {q_r[k-1][QB-2:0], ge};
        run_r[k] <= run_r[k-1];
        one_r[k] <= one_r[k-1];
      end
    end
  end

  assign out_vld = v_r[QB];
  assign quo = one_r[QB] ? ((QB+1)'(1) << QB) :
               run_r[QB] ? {1'b0, q_r[QB]} : '0;

endmodule

// ----- rtl/ssc_sqrt.sv -----
// Pipelined integer square root, one root bit per stage, saturating.
module ssc_sqrt #(
  parameter int OW = 34
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ssc_pkg::pipe_ctl_t ctl,
  input  logic [2*OW+1:0]    rad,
  output logic               out_vld,
  output logic [OW-1:0]      root
);

  localparam int SW = 2 * OW + 2;

  logic [SW-1:0] rem_r  [OW];
  logic [OW-1:0] root_r [OW];
  logic          v_r    [OW];

  for (genvar k = 0; k < OW; k++) begin : g_bit
    localparam int B = OW - 1 - k;
    logic [SW-1:0] rem_in;
    logic [OW-1:0] root_in;
    logic          v_in;
    logic [SW-1:0] term;
    logic          take;

    if (k == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
      assign v_in    = ctl.vld;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign v_in    = v_r[k-1];
    end

    // Growth of the square when this bit is set
    assign term = (SW'(root_in) << (B + 1)) + (SW'(1) << (2 * B));
    assign take = term <= rem_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (ctl.en) begin
        v_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl.en) begin
        rem_r[k]  <= take ? rem_in - term : rem_in;
        root_r[k] <= take ? (root_in | (OW'(1) << B)) : root_in;
      end
    end
  end

  assign out_vld = v_r[OW-1];
  assign root    = root_r[OW-1];

endmodule

// ----- rtl/segment_segment_closest_points.sv -----
// Throughput: one segment pair per cycle; the whole pipeline holds while the result waits.
// Stages: edge vectors, dot products, wide 2-stage multipliers, case split, a divider of
// FRAC_BITS+1 stages, gap and squares, a square root of COORD_WIDTH+2 stages, output register.
// Reset (rst_n low, synchronous) clears every stage valid bit; payload registers keep values.
// Top level: closest points of two 3-D segments.
module segment_segment_closest_points #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16,
  localparam int IN_DW  = ((12 * COORD_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((4 * (COORD_WIDTH + 2) + 2 * (FRAC_BITS + 1) + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // first_start_x/y/z, first_end_x/y/z, second_start_x/y/z, second_end_x/y/z
  input  logic [IN_DW-1:0]  in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // min_distance, gap_x, gap_y, gap_z, weight_first, weight_second
  output logic [OUT_DW-1:0] out_tdata
);

  localparam int CW = COORD_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int DW = 2 * CW + 4;
  localparam int PW = 2 * DW + 2;
  localparam int OW = CW + 2;
  localparam int GW = CW + FB + 4;
  localparam int QW = FB + 1;
  localparam int SW = 2 * OW + 2;
  localparam int EW = 9 * (CW + 1);
  localparam int TW = 3 * OW + 2 * QW;
  localparam logic signed [GW-1:0] HALF = GW'(1) << (FB - 1);
  localparam logic signed [GW-1:0] GMAX = (GW'(1) << (OW - 1)) - GW'(1);
  localparam logic signed [GW-1:0] GMIN = ~GMAX;
  localparam logic signed [PW-1:0] PZERO = '0;
  localparam logic signed [PW-1:0] PONE  = PW'(1);

  logic en;
  ssc_pkg::pipe_ctl_t ctl7, ctl_g4;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  // Stage 1: edge vectors and offsets
  logic signed [CW-1:0] p [12];
  logic signed [CW:0]   e_r [3], f_r [3], w_r [3], rel_r [3];
  logic                 v1_r;

  always_comb begin
    for (int c = 0; c < 12; c++) begin
      p[c] = $signed(in_tdata[c*CW +: CW]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        e_r[c]   <= (CW+1)'(p[3+c]) - (CW+1)'(p[c]);
        f_r[c]   <= (CW+1)'(p[9+c]) - (CW+1)'(p[6+c]);
        w_r[c]   <= (CW+1)'(p[c]) - (CW+1)'(p[6+c]);
        rel_r[c] <= (CW+1)'(p[6+c]) - (CW+1)'(p[c]);
      end
    end
  end

  // Stage 2: component products of the five dot products
  logic signed [2*CW+1:0] ee_r [3], ef_r [3], ff_r [3], ew_r [3], fw_r [3];
  logic                   v2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        ee_r[c] <= e_r[c] * e_r[c];
        ef_r[c] <= e_r[c] * f_r[c];
        ff_r[c] <= f_r[c] * f_r[c];
        ew_r[c] <= e_r[c] * w_r[c];
        fw_r[c] <= f_r[c] * w_r[c];
      end
    end
  end

  // Stage 3: dot product sums a1..a5
  logic signed [DW-1:0] a1_r, a2_r, a3_r, a4_r, a5_r;
  logic                 v3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r <= DW'(ee_r[0]) + DW'(ee_r[1]) + DW'(ee_r[2]);
      a2_r <= DW'(ef_r[0]) + DW'(ef_r[1]) + DW'(ef_r[2]);
      a3_r <= DW'(ff_r[0]) + DW'(ff_r[1]) + DW'(ff_r[2]);
      a4_r <= DW'(ew_r[0]) + DW'(ew_r[1]) + DW'(ew_r[2]);
      a5_r <= DW'(fw_r[0]) + DW'(fw_r[1]) + DW'(fw_r[2]);
    end
  end

  // Stages 4-5: wide products for det and the region tests
  logic signed [2*DW-1:0] m13, m22, m25, m34, m15, m24;
  logic [5*DW-1:0]        a_dly;
  logic signed [DW-1:0]   a1_d, a2_d, a3_d, a4_d, a5_d;
  logic                   v4_r, v5_r;

  ssc_mul #(.W(DW)) u_mul13 (.clk(clk), .en(en), .a(a1_r), .b(a3_r), .p(m13));
  ssc_mul #(.W(DW)) u_mul22 (.clk(clk), .en(en), .a(a2_r), .b(a2_r), .p(m22));
  ssc_mul #(.W(DW)) u_mul25 (.clk(clk), .en(en), .a(a2_r), .b(a5_r), .p(m25));
  ssc_mul #(.W(DW)) u_mul34 (.clk(clk), .en(en), .a(a3_r), .b(a4_r), .p(m34));
  ssc_mul #(.W(DW)) u_mul15 (.clk(clk), .en(en), .a(a1_r), .b(a5_r), .p(m15));
  ssc_mul #(.W(DW)) u_mul24 (.clk(clk), .en(en), .a(a2_r), .b(a4_r), .p(m24));

  ssc_delay #(.W(5*DW), .DEPTH(2)) u_a_dly (
    .clk(clk), .en(en), .d({a5_r, a4_r, a3_r, a2_r, a1_r}), .q(a_dly)
  );

  assign a1_d = $signed(a_dly[0*DW +: DW]);
  assign a2_d = $signed(a_dly[1*DW +: DW]);
  assign a3_d = $signed(a_dly[2*DW +: DW]);
  assign a4_d = $signed(a_dly[3*DW +: DW]);
  assign a5_d = $signed(a_dly[4*DW +: DW]);

  // Stage 6: determinant, numerators and helper sums
  logic signed [PW-1:0] det_r, sn_r, tn_r, u_r, ma4_r, a2ma4_r, x1_r, x3_r, x5_r;
  logic                 v6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      det_r   <= PW'(m13) - PW'(m22);
      sn_r    <= PW'(m25) - PW'(m34);
      tn_r    <= PW'(m15) - PW'(m24);
      u_r     <= PW'(a2_d) + PW'(a5_d);
      ma4_r   <= -PW'(a4_d);
      a2ma4_r <= PW'(a2_d) - PW'(a4_d);
      x1_r    <= PW'(a1_d);
      x3_r    <= PW'(a3_d);
      x5_r    <= PW'(a5_d);
    end
  end

  // Stage 7: region split picks the fractions for s and t
  logic signed [PW-1:0] s_num_nxt, s_den_nxt, t_num_nxt, t_den_nxt;
  logic signed [PW-1:0] s_num_r, s_den_r, t_num_r, t_den_r;
  logic                 v7_r;

  always_comb begin
    s_num_nxt = ma4_r;
    s_den_nxt = x1_r;
    t_num_nxt = PZERO;
    t_den_nxt = PONE;
    if (det_r > 0) begin
      if (sn_r <= 0) begin
        if (x5_r <= 0) begin
          s_num_nxt = ma4_r;   s_den_nxt = x1_r; t_num_nxt = PZERO; t_den_nxt = PONE;
        end else if (x5_r < x3_r) begin
          s_num_nxt = PZERO;   s_den_nxt = PONE; t_num_nxt = x5_r;  t_den_nxt = x3_r;
        end else begin
          s_num_nxt = a2ma4_r; s_den_nxt = x1_r; t_num_nxt = PONE;  t_den_nxt = PONE;
        end
      end else if (sn_r >= det_r) begin
        if (u_r <= 0) begin
          s_num_nxt = ma4_r;   s_den_nxt = x1_r; t_num_nxt = PZERO; t_den_nxt = PONE;
        end else if (u_r < x3_r) begin
          s_num_nxt = PONE;    s_den_nxt = PONE; t_num_nxt = u_r;   t_den_nxt = x3_r;
        end else begin
          s_num_nxt = a2ma4_r; s_den_nxt = x1_r; t_num_nxt = PONE;  t_den_nxt = PONE;
        end
      end else if (tn_r <= 0) begin
        s_num_nxt = ma4_r;   s_den_nxt = x1_r;  t_num_nxt = PZERO; t_den_nxt = PONE;
      end else if (tn_r >= det_r) begin
        s_num_nxt = a2ma4_r; s_den_nxt = x1_r;  t_num_nxt = PONE;  t_den_nxt = PONE;
      end else begin
        s_num_nxt = sn_r;    s_den_nxt = det_r; t_num_nxt = tn_r;  t_den_nxt = det_r;
      end
    end else begin
      if (x5_r <= 0) begin
        s_num_nxt = ma4_r;   s_den_nxt = x1_r; t_num_nxt = PZERO; t_den_nxt = PONE;
      end else if (x5_r >= x3_r) begin
        s_num_nxt = a2ma4_r; s_den_nxt = x1_r; t_num_nxt = PONE;  t_den_nxt = PONE;
      end else begin
        s_num_nxt = PZERO;   s_den_nxt = PONE; t_num_nxt = x5_r;  t_den_nxt = x3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_num_r <= s_num_nxt;
      s_den_r <= s_den_nxt;
      t_num_r <= t_num_nxt;
      t_den_r <= t_den_nxt;
    end
  end

  // Front valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
    end
  end

  // Dividers for s and t
  logic [QW-1:0] s_q, t_q;
  logic          dv_v, dv_t_v;

  assign ctl7.en  = en;
  assign ctl7.vld = v7_r;

  ssc_div #(.NW(PW), .QB(FB)) u_div_s (
    .clk(clk), .rst_n(rst_n), .ctl(ctl7), .num(s_num_r), .den(s_den_r),
    .out_vld(dv_v), .quo(s_q)
  );

  ssc_div #(.NW(PW), .QB(FB)) u_div_t (
    .clk(clk), .rst_n(rst_n), .ctl(ctl7), .num(t_num_r), .den(t_den_r),
    .out_vld(dv_t_v), .quo(t_q)
  );

  // Carry edge vectors and offsets alongside the dividers
  logic [EW-1:0]      efr_dly;
  logic signed [CW:0] e_d [3], f_d [3], rel_d [3];

  ssc_delay #(.W(EW), .DEPTH(FB + 7)) u_efr_dly (
    .clk(clk), .en(en),
    .d({rel_r[2], rel_r[1], rel_r[0], f_r[2], f_r[1], f_r[0], e_r[2], e_r[1], e_r[0]}),
    .q(efr_dly)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      e_d[c]   = $signed(efr_dly[c*(CW+1) +: CW+1]);
      f_d[c]   = $signed(efr_dly[(3+c)*(CW+1) +: CW+1]);
      rel_d[c] = $signed(efr_dly[(6+c)*(CW+1) +: CW+1]);
    end
  end

  // Gap stage 1: scaled terms and weights
  logic signed [GW-1:0] rs_r [3], tf_r [3], se_r [3];
  logic [QW-1:0]        wf1_r, ws1_r;
  logic                 g1_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        rs_r[c] <= GW'(rel_d[c]) <<< FB;
        tf_r[c] <= GW'($signed({1'b0, t_q}) * f_d[c]);
        se_r[c] <= GW'($signed({1'b0, s_q}) * e_d[c]);
      end
      wf1_r <= (QW'(1) << FB) - s_q;
      ws1_r <= (QW'(1) << FB) - t_q;
    end
  end

  // Gap stage 2: sum, round to nearest, saturate
  logic signed [GW-1:0] v_sum [3], v_sh [3];
  logic signed [OW-1:0] g_nxt [3];
  logic signed [OW-1:0] g2_r [3];
  logic [QW-1:0]        wf2_r, ws2_r;
  logic                 g2_v_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      v_sum[c] = rs_r[c] + tf_r[c] - se_r[c] + HALF;
      v_sh[c]  = v_sum[c] >>> FB;
      if (v_sh[c] > GMAX) begin
        g_nxt[c] = GMAX[OW-1:0];
      end else if (v_sh[c] < GMIN) begin
        g_nxt[c] = GMIN[OW-1:0];
      end else begin
        g_nxt[c] = v_sh[c][OW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        g2_r[c] <= g_nxt[c];
      end
      wf2_r <= wf1_r;
      ws2_r <= ws1_r;
    end
  end

  // Gap stage 3: squares
  logic signed [2*OW-1:0] sq_r [3];
  logic signed [OW-1:0]   g3_r [3];
  logic [QW-1:0]          wf3_r, ws3_r;
  logic                   g3_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        sq_r[c] <= g2_r[c] * g2_r[c];
        g3_r[c] <= g2_r[c];
      end
      wf3_r <= wf2_r;
      ws3_r <= ws2_r;
    end
  end

  // Gap stage 4: squared length
  logic [SW-1:0]        sum_r;
  logic signed [OW-1:0] g4_r [3];
  logic [QW-1:0]        wf4_r, ws4_r;
  logic                 g4_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      sum_r <= SW'(unsigned'(sq_r[0])) + SW'(unsigned'(sq_r[1]))
             + SW'(unsigned'(sq_r[2]));
      for (int c = 0; c < 3; c++) begin
        g4_r[c] <= g3_r[c];
      end
      wf4_r <= wf3_r;
      ws4_r <= ws3_r;
    end
  end

  // Back valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g1_v_r <= 1'b0;
      g2_v_r <= 1'b0;
      g3_v_r <= 1'b0;
      g4_v_r <= 1'b0;
    end else if (en) begin
      g1_v_r <= dv_v;
      g2_v_r <= g1_v_r;
      g3_v_r <= g2_v_r;
      g4_v_r <= g3_v_r;
    end
  end

  // Square root with gap and weights riding alongside
  logic [OW-1:0] root;
  logic          sq_v;
  logic [TW-1:0] tail_dly;

  assign ctl_g4.en  = en;
  assign ctl_g4.vld = g4_v_r;

  ssc_sqrt #(.OW(OW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .ctl(ctl_g4), .rad(sum_r), .out_vld(sq_v), .root(root)
  );

  ssc_delay #(.W(TW), .DEPTH(OW)) u_tail_dly (
    .clk(clk), .en(en),
    .d({ws4_r, wf4_r, g4_r[2], g4_r[1], g4_r[0]}),
    .q(tail_dly)
  );

  // Output register
  logic          out_valid_r;
  logic [OW-1:0] dist_r, gx_r, gy_r, gz_r;
  logic [QW-1:0] wf_r, ws_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist_r <= root;
      gx_r   <= tail_dly[0*OW +: OW];
      gy_r   <= tail_dly[1*OW +: OW];
      gz_r   <= tail_dly[2*OW +: OW];
      wf_r   <= tail_dly[3*OW +: QW];
      ws_r   <= tail_dly[3*OW+QW +: QW];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({ws_r, wf_r, gz_r, gy_r, gx_r, dist_r});

`ifndef ASSERT_OFF
  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (wf_r <= (QW'(1) << FB)) && (ws_r <= (QW'(1) << FB)))
    else $error("weight above one");

  a_zero_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (gx_r == '0) && (gy_r == '0) && (gz_r == '0) |-> dist_r == '0)
    else $error("nonzero distance for zero gap");

  a_nonzero_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (dist_r != '0) |-> ((gx_r | gy_r | gz_r) != '0))
    else $error("distance without gap");

  a_div_align: assert property (@(posedge clk) disable iff (!rst_n)
    dv_v == dv_t_v)
    else $error("divider valid bits out of step");
`endif

endmodule

// ----- test/testbench.sv -----
// Self-checking testbench for the segment pair closest-point pipeline.
`timescale 1ns / 100ps

module testbench;

  localparam int COORD_WIDTH = 32;
  localparam int FRAC_BITS   = 16;
  localparam int IN_DW       = 384;
  localparam int OUT_DW      = 176;
  localparam int PAIR_COUNT  = 1750;
  localparam int CALM_COUNT  = 250;
  localparam int DRAIN_CYCLES = 100;
  localparam int DIR_COUNT   = 14;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef coord_t pair_t [12];
  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic [33:0]        min_distance;
    logic signed [33:0] gap_x;
    logic signed [33:0] gap_y;
    logic signed [33:0] gap_z;
    logic [16:0]        weight_first;
    logic [16:0]        weight_second;
  } closest_t;

  localparam coord_t ONE  = 32'sh0001_0000;
  localparam coord_t CMAX = 32'sh7fff_ffff;
  localparam coord_t CMIN = 32'sh8000_0000;
  localparam wide_t  ONE_W   = 256'sd65536;
  localparam wide_t  GAP_MAX = 256'sh1_ffff_ffff;
  localparam wide_t  GAP_MIN = -GAP_MAX - 256'sd1;

  logic              clk;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_DW-1:0]  in_tdata;
  logic              out_tvalid;
  logic              out_tready;
  logic [OUT_DW-1:0] out_tdata;

  closest_t pending_q [$];
  bit       failed;
  bit       calm;

  segment_segment_closest_points u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #2 clk = ~clk;

  // Clamp a parameter quotient to [0, one].
  function automatic wide_t clamp_ratio(wide_t num, wide_t den);
    if (num <= 0) return 0;
    if (num >= den) return ONE_W;
    if (den <= 0) return 0;
    return (num <<< FRAC_BITS) / den;
  endfunction

  function automatic wide_t dot3(wide_t x [3], wide_t y [3]);
    return x[0] * y[0] + x[1] * y[1] + x[2] * y[2];
  endfunction

  // Compute the closest-point parameters, gap vector, distance and weights of one pair.
  function automatic closest_t predict_closest(pair_t p);
    wide_t    e [3], f [3], w [3], g [3];
    wide_t    a1, a2, a3, a4, a5, det, b1, b2, b3, b4, sn, tn, u, s, t, v, sum, root, cand;
    closest_t r;
    for (int k = 0; k < 3; k++) begin
      e[k] = p[3 + k] - p[k];
      f[k] = p[9 + k] - p[6 + k];
      w[k] = p[k] - p[6 + k];
    end
    a1 = dot3(e, e);
    a2 = dot3(e, f);
    a3 = dot3(f, f);
    a4 = dot3(e, w);
    a5 = dot3(f, w);
    det = a1 * a3 - a2 * a2;
    if (det > 0) begin
      b1 = a2 * a5;
      b2 = a3 * a4;
      if (b1 <= b2) begin
        if (a5 <= 0) begin s = clamp_ratio(-a4, a1); t = 0; end
        else if (a5 < a3) begin s = 0; t = clamp_ratio(a5, a3); end
        else begin s = clamp_ratio(a2 - a4, a1); t = ONE_W; end
      end else begin
        sn = b1 - b2;
        if (sn >= det) begin
          u = a2 + a5;
          if (u <= 0) begin s = clamp_ratio(-a4, a1); t = 0; end
          else if (u < a3) begin s = ONE_W; t = clamp_ratio(u, a3); end
          else begin s = clamp_ratio(a2 - a4, a1); t = ONE_W; end
        end else begin
          b3 = a1 * a5;
          b4 = a2 * a4;
          if (b3 <= b4) begin s = clamp_ratio(-a4, a1); t = 0; end
          else begin
            tn = b3 - b4;
            if (tn >= det) begin s = clamp_ratio(a2 - a4, a1); t = ONE_W; end
            else begin s = clamp_ratio(sn, det); t = clamp_ratio(tn, det); end
          end
        end
      end
    end else begin
      // parallel or degenerate segments
      if (a5 <= 0) begin s = clamp_ratio(-a4, a1); t = 0; end
      else if (a5 >= a3) begin s = clamp_ratio(a2 - a4, a1); t = ONE_W; end
      else begin s = 0; t = clamp_ratio(a5, a3); end
    end
    sum = 0;
    for (int k = 0; k < 3; k++) begin
      v = -w[k] * ONE_W + t * f[k] - s * e[k] + (ONE_W >>> 1);
      v = v >>> FRAC_BITS;
      if (v > GAP_MAX) v = GAP_MAX;
      else if (v < GAP_MIN) v = GAP_MIN;
      g[k] = v;
      sum += v * v;
    end
    // floor square root, one bit at a time
    root = 0;
    for (int b = 33; b >= 0; b--) begin
      cand = root | (wide_t'(1) <<< b);
      if (cand * cand <= sum) root = cand;
    end
    r.min_distance  = root[33:0];
    r.gap_x         = g[0][33:0];
    r.gap_y         = g[1][33:0];
    r.gap_z         = g[2][33:0];
    r.weight_first  = 17'h10000 - s[16:0];
    r.weight_second = 17'h10000 - t[16:0];
    return r;
  endfunction

  function automatic pair_t random_pair();
    pair_t p;
    int    mode;
    int    bits;
    mode = $urandom_range(0, 9);
    bits = $urandom_range(8, 32);
    for (int k = 0; k < 12; k++) begin
      if (mode >= 4 && mode <= 5) p[k] = $urandom;
      else if (mode == 9) begin
        case ($urandom_range(0, 3))
          0: p[k] = CMAX;
          1: p[k] = CMIN;
          2: p[k] = 0;
          default: p[k] = $urandom;
        endcase
      end else p[k] = $signed($urandom) >>> (32 - bits);
    end
    case (mode)
      // per axis, give the first or the second segment zero extent
      6: begin
        for (int k = 0; k < 3; k++) begin
          if ($urandom_range(0, 1)) p[3 + k] = p[k];
          else p[9 + k] = p[6 + k];
        end
      end
      // parallel or anti-parallel edges
      7: begin
        bit flip;
        flip = $urandom_range(0, 1);
        for (int k = 0; k < 3; k++)
          p[9 + k] = flip ? p[6 + k] - (p[3 + k] - p[k]) : p[6 + k] + (p[3 + k] - p[k]);
      end
      // shared endpoint
      8: for (int k = 0; k < 3; k++) p[6 + k] = p[3 + k];
      default: ;
    endcase
    return p;
  endfunction

  // Drive one pair and hold it until the transfer.
  task automatic send_pair(pair_t p, closest_t want);
    logic [IN_DW-1:0] word;
    word = '0;
    for (int k = 0; k < 12; k++) word[k * COORD_WIDTH +: COORD_WIDTH] = p[k];
    in_tdata  <= word;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pending_q = {pending_q, want};
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Stall the result side in random bursts.
  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end
      out_tready <= 1'b1;
    end
  end

  // Check each result transfer against the oldest expectation.
  always @(posedge clk) begin
    closest_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = {out_tdata[33:0], out_tdata[67:34], out_tdata[101:68], out_tdata[135:102],
             out_tdata[152:136], out_tdata[169:153]};
      if (pending_q.size() == 0) begin
        $error("result with no expectation waiting");
        failed = 1'b1;
      end else begin
        want = pending_q.pop_front();
        if (got.min_distance !== want.min_distance) begin
          $error("min_distance expected %0d actual %0d", want.min_distance, got.min_distance);
          failed = 1'b1;
        end
        if (got.gap_x !== want.gap_x) begin
          $error("gap_x expected %0d actual %0d", want.gap_x, got.gap_x);
          failed = 1'b1;
        end
        if (got.gap_y !== want.gap_y) begin
          $error("gap_y expected %0d actual %0d", want.gap_y, got.gap_y);
          failed = 1'b1;
        end
        if (got.gap_z !== want.gap_z) begin
          $error("gap_z expected %0d actual %0d", want.gap_z, got.gap_z);
          failed = 1'b1;
        end
        if (got.weight_first !== want.weight_first) begin
          $error("weight_first expected %0d actual %0d", want.weight_first, got.weight_first);
          failed = 1'b1;
        end
        if (got.weight_second !== want.weight_second) begin
          $error("weight_second expected %0d actual %0d", want.weight_second,
                 got.weight_second);
          failed = 1'b1;
        end
      end
    end
  end

  // Stimulus: directed table, then random pairs.
  initial begin
    pair_t    dir_tab [DIR_COUNT];
    closest_t known [2];
    pair_t    p;
    clk       = 1'b0;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    failed    = 1'b0;
    calm      = 1'b0;

    // all points at the origin
    dir_tab[0] = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0};
    known[0] = '{0, 0, 0, 0, 17'h10000, 17'h10000};
    // parallel unit segments one apart in y
    dir_tab[1] = '{0, 0, 0, ONE, 0, 0, 0, ONE, 0, ONE, ONE, 0};
    known[1] = '{34'h10000, 0, 34'h10000, 0, 17'h10000, 17'h10000};
    // skew perpendicular segments one apart in z
    dir_tab[2] = '{-ONE, 0, 0, ONE, 0, 0, 0, -ONE, ONE, 0, ONE, ONE};
    // first segment a point
    dir_tab[3] = '{ONE, 2 * ONE, 3 * ONE, ONE, 2 * ONE, 3 * ONE, 0, 0, 0, 2 * ONE, 0, 0};
    // second segment a point
    dir_tab[4] = '{0, 0, 0, 2 * ONE, 0, 0, ONE, -ONE, 5, ONE, -ONE, 5};
    // both segments points
    dir_tab[5] = '{7, 8, 9, 7, 8, 9, -3, 4, -5, -3, 4, -5};
    // every coordinate at the maximum
    dir_tab[6] = '{CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX};
    // full-range diagonal against a mixed one
    dir_tab[7] = '{CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN};
    // anti-parallel full-range diagonals
    dir_tab[8] = '{CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMAX, CMAX, CMAX};
    // skew, both parameters clamped to an end
    dir_tab[9] = '{0, 0, 0, ONE, 0, 0, 2 * ONE, ONE, 0, 3 * ONE, 5 * ONE, ONE};
    // collinear overlap
    dir_tab[10] = '{0, 0, 0, 4 * ONE, 0, 0, 2 * ONE, 0, 0, 6 * ONE, 0, 0};
    // anti-parallel offset
    dir_tab[11] = '{0, 0, 0, 2 * ONE, 0, 0, 3 * ONE, ONE, 0, -ONE, ONE, 0};
    // alternating extremes
    dir_tab[12] = '{CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMAX};
    // interior solution with fractional parameters
    dir_tab[13] = '{-3 * ONE, ONE, 7, 5 * ONE, -2 * ONE, 11, ONE, -4 * ONE, 3 * ONE,
                    -ONE, 6 * ONE, -2 * ONE};

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      send_pair(dir_tab[i], (i < 2) ? known[i] : predict_closest(dir_tab[i]));
    end
    for (int n = 0; n < PAIR_COUNT; n++) begin
      if (n == PAIR_COUNT - CALM_COUNT) calm = 1'b1;
      p = random_pair();
      send_pair(p, predict_closest(p));
    end
    in_tvalid <= 1'b0;

    // drain the pipeline
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (!failed) begin
      $display("segment_segment_closest_points: match");
    end else begin
      $display("segment_segment_closest_points: mismatch");
    end
    $finish;
  end

  // Give up if the run hangs.
  initial begin
    #4000000;
    $display("segment_segment_closest_points: mismatch");
    $finish;
  end

endmodule
